FILE: rtl/spf_pkg.sv
// ----------------------------------------------------------------------------
// spf_pkg
// Shared types, constants and the per-pixel entry update for the static
// pixel state machine.
// ----------------------------------------------------------------------------
package spf_pkg;

  // Store geometry
  localparam int IMAGE_WIDTH_DEF  = 256;
  localparam int IMAGE_HEIGHT_DEF = 256;
  localparam int STORE_MAX        = 65536;
  localparam int INDEX_W          = 16;

  // Output queue depth
  localparam int FIFO_DEPTH = 4;

  // Configuration
  localparam int          PADDR_W         = 3;
  localparam int          PDATA_W         = 32;
  localparam int          REG_HOLD_FRAMES = 0;
  localparam logic [7:0]  HOLD_RESET      = 8'd15;
  localparam logic [7:0]  COUNT_MAX       = 8'hFF;

  // Item kinds (tuser)
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // Pixel classes
  localparam logic [1:0] CLS_BG   = 2'd0;
  localparam logic [1:0] CLS_LONG = 2'd1;
  localparam logic [1:0] CLS_BOTH = 2'd3;

  typedef struct packed {
    logic [1:0] cls;
    logic       cand;
    logic       stable;
    logic [7:0] count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Packed so that candidate_static lands in bit 0
  typedef struct packed {
    logic moving_fg;
    logic stable_static;
    logic candidate_static;
  } result_t;

  localparam int RESULT_W = $bits(result_t);

  function automatic logic [1:0] pix_class(logic short_fg, logic long_fg);
    logic [1:0] c;
    if (!long_fg) begin
      c = CLS_BG;
    end else if (short_fg) begin
      c = CLS_BOTH;
    end else begin
      c = CLS_LONG;
    end
    return c;
  endfunction

  // Next entry for a pixel update of class now
  function automatic entry_t entry_next(entry_t cur, logic [1:0] now, logic [7:0] hold);
    entry_t e;
    e = cur;
    if (now == CLS_LONG && cur.cls == CLS_LONG) begin
      if (cur.count == hold) begin
        e.stable = 1'b1;
      end
      if (cur.cand && cur.count != COUNT_MAX) begin
        e.count = cur.count + 8'd1;
      end
    end else begin
      e.count = 8'd0;
      e.cand  = 1'b0;
    end
    if (now == CLS_LONG && cur.cls == CLS_BOTH) begin
      e.cand = 1'b1;
    end
    e.cls = now;
    return e;
  endfunction

endpackage

FILE: rtl/spf_ram.sv
// ----------------------------------------------------------------------------
// spf_ram
// Generic single-write, single-read RAM with registered read (old data on
// a same-address read and write).
// ----------------------------------------------------------------------------
module spf_ram #(
  parameter int WIDTH  = 12,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/spf_update.sv
// ----------------------------------------------------------------------------
// spf_update
// Read-modify-write stage: takes the entry read from the store, forwards
// the previous write on an address match, applies the state update and
// produces the write-back and the result.
// ----------------------------------------------------------------------------
module spf_update #(
  parameter int ADDR_W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_kind,
  input  logic [ADDR_W-1:0]    in_addr,
  input  logic                 in_range,
  input  logic                 in_short,
  input  logic                 in_long,
  input  spf_pkg::entry_t      rd_entry,
  input  logic [7:0]           hold_frames,
  output logic                 busy,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output spf_pkg::entry_t      wr_entry,
  output logic                 push,
  output spf_pkg::result_t     push_data
);

  logic              s1_valid;
  logic              s1_kind;
  logic [ADDR_W-1:0] s1_addr;
  logic              s1_range;
  logic              s1_short;
  logic              s1_long;

  logic              fw_valid;
  logic [ADDR_W-1:0] fw_addr;
  spf_pkg::entry_t   fw_entry;

  spf_pkg::entry_t   cur;
  spf_pkg::entry_t   upd;
  logic [1:0]        now;

  // Stage register, follows the read issued at accept
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
    end
    s1_kind  <= in_kind;
    s1_addr  <= in_addr;
    s1_range <= in_range;
    s1_short <= in_short;
    s1_long  <= in_long;
  end

  // Last write, landing on the same edge as the current item's read
  always_ff @(posedge clk) begin
    if (rst) begin
      fw_valid <= 1'b0;
    end else begin
      fw_valid <= wr_en;
    end
    fw_addr  <= wr_addr;
    fw_entry <= wr_entry;
  end

  // Forward, then update
  always_comb begin
    cur = (fw_valid && fw_addr == s1_addr) ? fw_entry : rd_entry;
    now = spf_pkg::pix_class(s1_short, s1_long);
    upd = spf_pkg::entry_next(cur, now, hold_frames);
  end

  assign busy    = s1_valid;
  assign wr_en   = s1_valid && s1_range;
  assign wr_addr = s1_addr;
  assign wr_entry = (s1_kind == spf_pkg::KIND_CLEAR) ? '0 : upd;

  // Result: zero for a clear or an out-of-image pixel
  always_comb begin
    push_data = '0;
    if (s1_range && s1_kind == spf_pkg::KIND_UPDATE) begin
      push_data.candidate_static = upd.cand;
      push_data.stable_static    = upd.stable;
      push_data.moving_fg        = (now == spf_pkg::CLS_BOTH);
    end
  end

  assign push = s1_valid;

endmodule

FILE: rtl/spf_out_fifo.sv
// ----------------------------------------------------------------------------
// spf_out_fifo
// Small result queue that decouples the update stage from the output
// stream. Space is reserved upstream, so a push never meets a full queue.
// ----------------------------------------------------------------------------
module spf_out_fifo (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  input  spf_pkg::result_t                   push_data,
  output logic [$clog2(spf_pkg::FIFO_DEPTH):0] count,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [7:0]                         m_tdata
);

  localparam int PTR_W = $clog2(spf_pkg::FIFO_DEPTH);

  spf_pkg::result_t mem [spf_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic             pop;

  assign m_tvalid = (count != '0);
  assign pop      = m_tvalid && m_tready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  assign m_tdata = {{(8 - spf_pkg::RESULT_W){1'b0}}, mem[rd_ptr]};

endmodule

FILE: rtl/static_pixel_fsm_core.sv
// ----------------------------------------------------------------------------
// static_pixel_fsm_core
// Each accepted item is registered in the update stage with its store read and
// its result goes into the result queue. Throughput one item per clock while
// s_tready is high; same-pixel updates in consecutive cycles are forwarded.
// s_tready is low when the four-entry queue plus the update-stage item reach four.
// Reset: synchronous, active high, then a clearing pass zeroes one entry per
// cycle (IMAGE_WIDTH*IMAGE_HEIGHT entries, at most 65536) with s_tready low.
// ----------------------------------------------------------------------------
module static_pixel_fsm_core #(
  parameter int IMAGE_WIDTH  = spf_pkg::IMAGE_WIDTH_DEF,
  parameter int IMAGE_HEIGHT = spf_pkg::IMAGE_HEIGHT_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [23:0]                 s_tdata,   // [15:0] pixel_index, [16] short_fg, [17] long_fg
  input  logic                        s_tuser,   // [0] kind
  // Result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // [0] candidate_static, [1] stable_static, [2] moving_fg
  // Configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [spf_pkg::PADDR_W-1:0] paddr,
  input  logic [spf_pkg::PDATA_W-1:0] pwdata,
  output logic [spf_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  localparam int NPIX        = IMAGE_WIDTH * IMAGE_HEIGHT;
  localparam int STORE_DEPTH = (NPIX < spf_pkg::STORE_MAX) ? NPIX : spf_pkg::STORE_MAX;
  localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(spf_pkg::FIFO_DEPTH) + 1;

  logic [7:0]              hold_frames;
  logic                    clearing;
  logic [ADDR_W-1:0]       clr_addr;
  logic                    accept;
  logic                    in_range;
  logic                    upd_busy;
  logic                    upd_we;
  logic [ADDR_W-1:0]       upd_waddr;
  spf_pkg::entry_t         upd_wentry;
  logic                    push;
  spf_pkg::result_t        push_data;
  logic [CNT_W-1:0]        fifo_count;
  logic                    ram_we;
  logic [ADDR_W-1:0]       ram_waddr;
  logic [spf_pkg::ENTRY_W-1:0] ram_wdata;
  logic [spf_pkg::ENTRY_W-1:0] ram_rdata;

  // Configuration register
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_frames <= spf_pkg::HOLD_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr == spf_pkg::PADDR_W'(spf_pkg::REG_HOLD_FRAMES * 4)) begin
      hold_frames <= pwdata[7:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == spf_pkg::PADDR_W'(spf_pkg::REG_HOLD_FRAMES * 4)) begin
      prdata = {{(spf_pkg::PDATA_W - 8){1'b0}}, hold_frames};
    end
  end

  // Clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // Input handshake: room reserved for every item in flight
  assign s_tready = !clearing &&
                    (({1'b0, fifo_count} + (CNT_W + 1)'(upd_busy)) <
                     (CNT_W + 1)'(spf_pkg::FIFO_DEPTH));
  assign accept   = s_tvalid && s_tready;
  assign in_range = {1'b0, s_tdata[15:0]} < 17'(STORE_DEPTH);

  // Store write port: clearing pass or write-back
  assign ram_we    = clearing || upd_we;
  assign ram_waddr = clearing ? clr_addr : upd_waddr;
  assign ram_wdata = clearing ? '0 : upd_wentry;

  spf_ram #(
    .WIDTH  (spf_pkg::ENTRY_W),
    .DEPTH  (STORE_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (s_tdata[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  spf_update #(
    .ADDR_W (ADDR_W)
  ) u_update (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (accept),
    .in_kind     (s_tuser),
    .in_addr     (s_tdata[ADDR_W-1:0]),
    .in_range    (in_range),
    .in_short    (s_tdata[16]),
    .in_long     (s_tdata[17]),
    .rd_entry    (spf_pkg::entry_t'(ram_rdata)),
    .hold_frames (hold_frames),
    .busy        (upd_busy),
    .wr_en       (upd_we),
    .wr_addr     (upd_waddr),
    .wr_entry    (upd_wentry),
    .push        (push),
    .push_data   (push_data)
  );

  spf_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .count     (fifo_count),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < CNT_W'(spf_pkg::FIFO_DEPTH)) || (m_tvalid && m_tready))
    else $error("result queue overflow");

  a_clear_zero: assert property (@(posedge clk) disable iff (rst)
    clearing |-> (ram_we && ram_wdata == '0))
    else $error("clearing pass wrote nonzero entry");

  a_no_update_in_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !upd_we)
    else $error("write-back collided with clearing pass");

  a_first_result: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_range) |=> (push && push_data == '0))
    else $error("out-of-image pixel produced nonzero result");

endmodule

FILE: test/static_pixel_fsm_core_tb.sv
// ----------------------------------------------------------------------------
// static_pixel_fsm_core_tb
// Self-checking bench for the static pixel state machine. A short directed
// walk covers the pixel classes, clear transfers, index extremes and a few
// hold settings. Randomized runs of class 3 followed by class 1 updates then
// drive pixels through candidate, stable and counter saturation. Results are
// checked against an in-bench copy of the per-pixel store.
// ----------------------------------------------------------------------------
module static_pixel_fsm_core_tb;
  import spf_pkg::*;

  localparam int IMAGE_PIXELS  = IMAGE_WIDTH_DEF * IMAGE_HEIGHT_DEF;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int LONG_STALL    = 400;
  localparam int DRAIN_CYCLES  = 6;
  localparam int PHASE_ITEMS   = 300;
  localparam int NUM_PHASES    = 5;
  localparam int NUM_STREAMS   = 4;

  // Per-pixel record kept by the bench
  typedef struct packed {
    logic [1:0] last_cls;
    logic       cand;
    logic       stable;
    logic [7:0] frames;
  } pix_rec_t;

  // Result flags, candidate in bit 0 as on m_tdata
  typedef struct packed {
    logic moving;
    logic stable;
    logic cand;
  } pix_flags_t;

  typedef enum logic {ROW_XFER, ROW_HOLD} row_op_e;

  typedef struct {
    row_op_e    op;
    logic       kind;
    logic [15:0] idx;
    logic       sfg;
    logic       lfg;
    bit         typed;
    pix_flags_t want;
    logic [7:0] hold;
  } stim_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [23:0]         s_tdata;   // [15:0] pixel_index, [16] short_fg, [17] long_fg
  logic                s_tuser;   // [0] kind
  logic                m_tvalid;
  logic                m_tready;
  logic [7:0]          m_tdata;   // [0] candidate_static, [1] stable_static, [2] moving_fg
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0]  pwdata;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  pix_rec_t    pix_mem [STORE_MAX];
  logic [7:0]  hold_setting;
  pix_flags_t  flags_due [$];
  stim_row_t   stim_rows [$];

  int  err_count;
  int  sent_count;
  int  checked_count;
  int  stable_seen;
  int  cycle_count;
  bit  quiet_tail;
  bit  long_stall_req;

  logic [15:0] run_pix  [NUM_STREAMS];
  int          run_left [NUM_STREAMS];

  static_pixel_fsm_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               flags_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("mismatch @%0t: %s", $time, what);
    err_count++;
  endtask

  // Update the bench store for one transfer and return the flags it yields
  function automatic pix_flags_t predict_pixel(logic kind, logic [15:0] idx, logic sfg,
                                               logic lfg);
    pix_rec_t   rec;
    logic [1:0] cls;
    pix_flags_t f;
    f = '0;
    if (int'(idx) >= IMAGE_PIXELS) return f;
    if (kind == KIND_CLEAR) begin
      pix_mem[idx] = '0;
      return f;
    end
    cls = !lfg ? CLS_BG : (sfg ? CLS_BOTH : CLS_LONG);
    rec = pix_mem[idx];
    if (cls == CLS_LONG && rec.last_cls == CLS_LONG) begin
      // stable check sees the count before it moves
      if (rec.frames == hold_setting) rec.stable = 1'b1;
      if (rec.cand && rec.frames != COUNT_MAX) rec.frames = rec.frames + 8'd1;
    end else begin
      rec.frames = '0;
      rec.cand   = 1'b0;
    end
    if (cls == CLS_LONG && rec.last_cls == CLS_BOTH) rec.cand = 1'b1;
    rec.last_cls = cls;
    pix_mem[idx] = rec;
    f.cand   = rec.cand;
    f.stable = rec.stable;
    f.moving = (cls == CLS_BOTH);
    return f;
  endfunction

  // Result monitor
  always @(posedge clk) begin
    pix_flags_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[2:0];
      if (flags_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result %b", m_tdata));
      end else begin
        want = flags_due.pop_front();
        checked_count++;
        if (got.stable) stable_seen++;
        if (got.cand !== want.cand)
          report_mismatch($sformatf("result %0d candidate_static %b want %b",
                                    checked_count, got.cand, want.cand));
        if (got.stable !== want.stable)
          report_mismatch($sformatf("result %0d stable_static %b want %b",
                                    checked_count, got.stable, want.stable));
        if (got.moving !== want.moving)
          report_mismatch($sformatf("result %0d moving_fg %b want %b",
                                    checked_count, got.moving, want.moving));
      end
    end
  end

  // Receiver: random stall bursts, one long hold-off on request
  initial begin
    forever begin
      if (long_stall_req) begin
        long_stall_req = 1'b0;
        m_tready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        m_tready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // One input transfer, with an optional idle burst after it
  task automatic send_pixel(input logic kind, input logic [15:0] idx, input logic sfg,
                            input logic lfg, input bit typed, input pix_flags_t want);
    pix_flags_t f;
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {6'd0, lfg, sfg, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    f = predict_pixel(kind, idx, sfg, lfg);
    flags_due.insert(flags_due.size(), typed ? want : f);
    sent_count++;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (flags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write, then read back
  task automatic write_hold(input logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * REG_HOLD_FRAMES);
    pwdata  <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    hold_setting = val;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== val)
      report_mismatch($sformatf("hold_frames reads %0d want %0d", prdata[7:0], val));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic void add_row(row_op_e op, logic kind, logic [15:0] idx, logic sfg,
                                  logic lfg, bit typed, pix_flags_t want, logic [7:0] hold);
    stim_row_t r;
    r.op = op; r.kind = kind; r.idx = idx; r.sfg = sfg; r.lfg = lfg;
    r.typed = typed; r.want = want; r.hold = hold;
    stim_rows.insert(stim_rows.size(), r);
  endfunction

  function automatic logic [15:0] pick_pixel();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 16'($urandom_range(0, 15));
    if (r < 15) return 16'hFFFF - 16'($urandom_range(0, 3));
    return 16'($urandom());
  endfunction

  // Random transfer: mostly class 3 then class 1 runs per stream, some noise
  task automatic send_random();
    int   s;
    logic sfg, lfg;
    s = $urandom_range(0, NUM_STREAMS - 1);
    if (run_left[s] == 0) begin
      if ($urandom_range(0, 9) < 7) begin
        run_pix[s]  = pick_pixel();
        run_left[s] = ($urandom_range(0, 23) == 0) ? $urandom_range(256, 262)
                                                    : $urandom_range(0, hold_setting + 4);
        send_pixel(KIND_UPDATE, run_pix[s], 1'b1, 1'b1, 1'b0, '0);
      end else begin
        send_pixel(($urandom_range(0, 3) == 0) ? KIND_CLEAR : KIND_UPDATE,
                   ($urandom_range(0, 1) == 0) ? pick_pixel() : run_pix[s],
                   1'($urandom()), 1'($urandom()), 1'b0, '0);
      end
    end else begin
      run_left[s]--;
      sfg = 1'b0;
      lfg = 1'b1;
      // occasionally break the run with a random class
      if ($urandom_range(0, 29) == 0) begin
        sfg = 1'($urandom());
        lfg = 1'($urandom());
      end
      send_pixel(KIND_UPDATE, run_pix[s], sfg, lfg, 1'b0, '0);
    end
  endtask

  // Stimulus
  initial begin
    logic [7:0] phase_hold [NUM_PHASES];
    s_tvalid <= 1'b0;
    s_tuser  <= KIND_UPDATE;
    s_tdata  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    rst      <= 1'b1;
    hold_setting = HOLD_RESET;
    foreach (pix_mem[i]) pix_mem[i] = '0;
    foreach (run_left[i]) begin
      run_left[i] = 0;
      run_pix[i]  = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows; want is {moving, stable, cand}
    add_row(ROW_XFER, KIND_UPDATE, 16'h0000, 1'b0, 1'b0, 1'b1, 3'b000, 8'd0); // background
    add_row(ROW_XFER, KIND_UPDATE, 16'hFFFF, 1'b1, 1'b1, 1'b1, 3'b100, 8'd0); // moving
    add_row(ROW_XFER, KIND_UPDATE, 16'hFFFF, 1'b0, 1'b1, 1'b1, 3'b001, 8'd0); // 3 -> 1
    add_row(ROW_XFER, KIND_UPDATE, 16'hFFFF, 1'b0, 1'b1, 1'b1, 3'b001, 8'd0); // counting
    add_row(ROW_XFER, KIND_CLEAR,  16'hFFFF, 1'b1, 1'b1, 1'b1, 3'b000, 8'd0); // clear
    add_row(ROW_XFER, KIND_UPDATE, 16'hFFFF, 1'b0, 1'b1, 1'b1, 3'b000, 8'd0); // 0 -> 1
    add_row(ROW_XFER, KIND_UPDATE, 16'h0000, 1'b1, 1'b0, 1'b1, 3'b000, 8'd0); // short alone
    // hold of zero: no candidate needed to turn stable
    add_row(ROW_HOLD, KIND_UPDATE, 16'h0000, 1'b0, 1'b0, 1'b0, 3'b000, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0002, 1'b0, 1'b1, 1'b1, 3'b000, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0002, 1'b0, 1'b1, 1'b1, 3'b010, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0002, 1'b1, 1'b1, 1'b1, 3'b110, 8'd0); // sticky
    add_row(ROW_XFER, KIND_UPDATE, 16'h0002, 1'b0, 1'b1, 1'b1, 3'b011, 8'd0);
    add_row(ROW_XFER, KIND_CLEAR,  16'h0002, 1'b0, 1'b0, 1'b1, 3'b000, 8'd0);
    // widest hold
    add_row(ROW_HOLD, KIND_UPDATE, 16'h0000, 1'b0, 1'b0, 1'b0, 3'b000, 8'd255);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0003, 1'b1, 1'b1, 1'b0, 3'b000, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0003, 1'b0, 1'b1, 1'b0, 3'b000, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0004, 1'b1, 1'b1, 1'b0, 3'b000, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0003, 1'b0, 1'b1, 1'b0, 3'b000, 8'd0);
    // hold of one: stable on the third class 1 in a row
    add_row(ROW_HOLD, KIND_UPDATE, 16'h0000, 1'b0, 1'b0, 1'b0, 3'b000, 8'd1);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0005, 1'b1, 1'b1, 1'b1, 3'b100, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0005, 1'b0, 1'b1, 1'b1, 3'b001, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0005, 1'b0, 1'b1, 1'b1, 3'b001, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0005, 1'b0, 1'b1, 1'b1, 3'b011, 8'd0);
    add_row(ROW_XFER, KIND_UPDATE, 16'h0005, 1'b0, 1'b0, 1'b1, 3'b010, 8'd0);

    foreach (stim_rows[i]) begin
      if (stim_rows[i].op == ROW_HOLD) begin
        wait_drained();
        write_hold(stim_rows[i].hold);
      end else begin
        send_pixel(stim_rows[i].kind, stim_rows[i].idx, stim_rows[i].sfg, stim_rows[i].lfg,
                   stim_rows[i].typed, stim_rows[i].want);
      end
    end

    // Random phases over several hold settings, last one without idling
    phase_hold[0] = 8'd0;
    phase_hold[1] = HOLD_RESET;
    phase_hold[2] = 8'd255;
    phase_hold[3] = 8'($urandom_range(1, 254));
    phase_hold[4] = 8'd3;
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_hold(phase_hold[p]);
      if (p == NUM_PHASES - 1) quiet_tail = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 1 && n == 20) long_stall_req = 1'b1;
        send_random();
      end
    end

    wait_drained();
    $display("sent %0d transfers, checked %0d results, %0d with stable_static set",
             sent_count, checked_count, stable_seen);
    $display("hold settings 15, 0, 255, 1, 3 and %0d; one long result-side stall",
             phase_hold[3]);
    if (err_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", err_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: static_pixel_fsm_core.f
rtl/spf_pkg.sv
rtl/spf_ram.sv
rtl/spf_update.sv
rtl/spf_out_fifo.sv
rtl/static_pixel_fsm_core.sv
test/static_pixel_fsm_core_tb.sv
